// ===== rtl/tspc_pkg.sv =====
// Shared types, constants and key masking functions for the tuple space classifier.
`default_nettype none

package tspc_pkg;

    localparam int MAX_TUPLES_DEF    = 32;
    localparam int MAX_ENTRIES_DEF   = 256;
    localparam int PRIORITY_BITS_DEF = 16;

    localparam logic REQ_INSERT   = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT    = 3'd0,
        ST_MISS   = 3'd1,
        ST_NEW    = 3'd2,
        ST_MERGED = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [5:0]  src_prefix_len;
        logic [5:0]  dst_prefix_len;
        logic [4:0]  sport_prefix_len;
        logic [4:0]  dport_prefix_len;
        logic [3:0]  proto_prefix_len;
        logic [15:0] rule_priority;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] match_priority;
    } rsp_t;

    // Prefix lengths of one tuple.
    typedef struct packed {
        logic [5:0] src;
        logic [5:0] dst;
        logic [4:0] sport;
        logic [4:0] dport;
        logic [3:0] proto;
    } tuple_len_t;

    // Five header fields as one key.
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } key_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic tscan;
        logic escan;
        logic restart;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_classify;
        logic scan_done;
        logic tfound;
        logic out_free;
    } sts_t;

    function automatic logic [5:0] sat_len(input logic [5:0] len, input logic [5:0] lim);
        return (len > lim) ? lim : len;
    endfunction

    function automatic tuple_len_t make_tuple(input req_t r);
        tuple_len_t t;
        t.src   = sat_len(r.src_prefix_len, 6'd32);
        t.dst   = sat_len(r.dst_prefix_len, 6'd32);
        t.sport = 5'(sat_len(6'(r.sport_prefix_len), 6'd16));
        t.dport = 5'(sat_len(6'(r.dport_prefix_len), 6'd16));
        t.proto = 4'(sat_len(6'(r.proto_prefix_len), 6'd8));
        return t;
    endfunction

    function automatic logic [31:0] mask32(input logic [5:0] len);
        logic [31:0] m;
        for (int i = 0; i < 32; i++) m[i] = ((7'(i) + 7'(len)) >= 7'd32);
        return m;
    endfunction

    function automatic logic [15:0] mask16(input logic [4:0] len);
        logic [15:0] m;
        for (int i = 0; i < 16; i++) m[i] = ((6'(i) + 6'(len)) >= 6'd16);
        return m;
    endfunction

    function automatic logic [7:0] mask8(input logic [3:0] len);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) m[i] = ((5'(i) + 5'(len)) >= 5'd8);
        return m;
    endfunction

    function automatic key_t mask_key(input key_t k, input tuple_len_t t);
        key_t r;
        r.src   = k.src & mask32(t.src);
        r.dst   = k.dst & mask32(t.dst);
        r.sport = k.sport & mask16(t.sport);
        r.dport = k.dport & mask16(t.dport);
        r.proto = k.proto & mask8(t.proto);
        return r;
    endfunction

    function automatic key_t req_key(input req_t r);
        key_t k;
        k.src   = r.src_addr;
        k.dst   = r.dst_addr;
        k.sport = r.src_port;
        k.dport = r.dst_port;
        k.proto = r.protocol;
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tspc_ctrl.sv =====
// Controller state machine that sequences tuple and entry scans.
`default_nettype none

module tspc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tspc_pkg::sts_t sts,
    output tspc_pkg::cmd_t      cmd
);
    import tspc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TSCAN  = 4'b0010,
        S_ESCAN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TSCAN;
                end
            end
            S_TSCAN:
            begin
                if (sts.is_classify)
                begin
                    state_next = S_ESCAN;
                end
                else
                begin
                    cmd.tscan = 1'b1;
                    if (sts.scan_done)
                    begin
                        if (sts.tfound)
                        begin
                            cmd.restart = 1'b1;
                            state_next  = S_ESCAN;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_ESCAN:
            begin
                cmd.escan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_TSCAN))
        else $error("accepted transfer did not start a scan");

    a_load_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("request loaded outside the idle state");

endmodule

`default_nettype wire

// ===== rtl/tspc_datapath.sv =====
// Datapath: tuple and entry stores, scan pipeline, compare and result register.
`default_nettype none

module tspc_datapath #(
    parameter int MAX_TUPLES    = tspc_pkg::MAX_TUPLES_DEF,
    parameter int MAX_ENTRIES   = tspc_pkg::MAX_ENTRIES_DEF,
    parameter int PRIORITY_BITS = tspc_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tspc_pkg::req_t req,
    input  wire tspc_pkg::cmd_t cmd,
    output tspc_pkg::sts_t      sts,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tspc_pkg::rsp_t      rsp
);
    import tspc_pkg::*;

    localparam int TIDX_W = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;
    localparam int EIDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TC_W   = $clog2(MAX_TUPLES + 1);
    localparam int EC_W   = $clog2(MAX_ENTRIES + 1);
    localparam int SC_W   = (TC_W > EC_W) ? TC_W : EC_W;
    localparam int PB     = PRIORITY_BITS;

    // Stores.
    tuple_len_t       tup_mem [MAX_TUPLES];
    key_t             ent_key_mem [MAX_ENTRIES];
    logic [TIDX_W-1:0] ent_tidx_mem [MAX_ENTRIES];
    logic [PB-1:0]    ent_prio_mem [MAX_ENTRIES];

    // Request registers.
    logic             is_cls_reg;
    key_t             pkt_reg;
    key_t             ins_key_reg;
    tuple_len_t       tuple_reg;
    logic [PB-1:0]    pri_reg;

    // Counters and scan state.
    logic [TC_W-1:0]  tuple_cnt_reg, tuple_cnt_next;
    logic [EC_W-1:0]  entry_cnt_reg, entry_cnt_next;
    logic [SC_W-1:0]  scan_idx_reg, scan_idx_next;
    logic             t1_vld_reg, e1_vld_reg, e2_vld_reg;
    logic [TIDX_W-1:0] t1_idx_reg;
    tuple_len_t       tup_rd_reg;
    key_t             e1_key_reg, e2_key_reg;
    logic [TIDX_W-1:0] e1_tidx_reg, e2_tidx_reg;
    logic [PB-1:0]    e1_prio_reg, e2_prio_reg;
    logic [EIDX_W-1:0] e1_idx_reg, e2_idx_reg;

    // Search results.
    logic             tfound_reg, efound_reg, hit_reg;
    logic [TIDX_W-1:0] tidx_found_reg;
    logic [EIDX_W-1:0] eidx_reg;
    logic [PB-1:0]    eprio_reg, best_reg;

    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic [SC_W-1:0]  scan_limit;
    logic             issue;
    logic [TIDX_W-1:0] tup_raddr;
    logic [31:0]      pri_wide;
    logic             t_match, e_ins_match, e_cls_match;
    logic             full;
    logic [PB-1:0]    merge_prio;
    logic             tup_we, ent_we;
    logic [TIDX_W-1:0] new_tidx;
    logic [EIDX_W-1:0] ent_waddr;
    logic [PB-1:0]    ent_wprio;
    rsp_t             rsp_next;

    assign pri_wide   = 32'(req.rule_priority);
    assign scan_limit = cmd.tscan ? SC_W'(tuple_cnt_reg) : SC_W'(entry_cnt_reg);
    assign issue      = (cmd.tscan || cmd.escan) && (scan_idx_reg != scan_limit);
    assign tup_raddr  = cmd.tscan ? scan_idx_reg[TIDX_W-1:0] : e1_tidx_reg;

    // Compares at the end of the scan pipeline.
    assign t_match     = t1_vld_reg && !tfound_reg && (tup_rd_reg == tuple_reg);
    assign e_ins_match = e2_vld_reg && !is_cls_reg && !efound_reg &&
                         (e2_tidx_reg == tidx_found_reg) && (e2_key_reg == ins_key_reg);
    assign e_cls_match = e2_vld_reg && is_cls_reg &&
                         (mask_key(pkt_reg, tup_rd_reg) == e2_key_reg) &&
                         (!hit_reg || (e2_prio_reg < best_reg));

    assign sts.is_classify = is_cls_reg;
    assign sts.scan_done   = (scan_idx_reg == scan_limit) && !t1_vld_reg &&
                             !e1_vld_reg && !e2_vld_reg;
    assign sts.tfound      = tfound_reg;
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    // Insert decision and result status, taken when the result is produced.
    always_comb
    begin
        full       = (entry_cnt_reg == EC_W'(MAX_ENTRIES)) ||
                     (!tfound_reg && (tuple_cnt_reg == TC_W'(MAX_TUPLES)));
        merge_prio = (pri_reg < eprio_reg) ? pri_reg : eprio_reg;
        new_tidx   = tfound_reg ? tidx_found_reg : tuple_cnt_reg[TIDX_W-1:0];
        ent_waddr  = efound_reg ? eidx_reg : entry_cnt_reg[EIDX_W-1:0];
        ent_wprio  = efound_reg ? merge_prio : pri_reg;
        tup_we     = 1'b0;
        ent_we     = 1'b0;
        tuple_cnt_next = tuple_cnt_reg;
        entry_cnt_next = entry_cnt_reg;
        rsp_next   = rsp_reg;
        if (cmd.finish)
        begin
            if (is_cls_reg)
            begin
                rsp_next.status         = hit_reg ? ST_HIT : ST_MISS;
                rsp_next.match_priority = hit_reg ? 16'(32'(best_reg)) : 16'd0;
            end
            else if (efound_reg)
            begin
                ent_we                  = 1'b1;
                rsp_next.status         = ST_MERGED;
                rsp_next.match_priority = 16'(32'(merge_prio));
            end
            else if (full)
            begin
                rsp_next.status         = ST_FULL;
                rsp_next.match_priority = 16'd0;
            end
            else
            begin
                ent_we         = 1'b1;
                tup_we         = !tfound_reg;
                entry_cnt_next = entry_cnt_reg + EC_W'(1);
                if (!tfound_reg)
                begin
                    tuple_cnt_next = tuple_cnt_reg + TC_W'(1);
                end
                rsp_next.status         = ST_NEW;
                rsp_next.match_priority = 16'(32'(pri_reg));
            end
        end
    end

    // Scan index.
    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        if (cmd.load || cmd.restart)
        begin
            scan_idx_next = '0;
        end
        else if (issue)
        begin
            scan_idx_next = scan_idx_reg + SC_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuple_cnt_reg <= '0;
            entry_cnt_reg <= '0;
            scan_idx_reg  <= '0;
            t1_vld_reg    <= 1'b0;
            e1_vld_reg    <= 1'b0;
            e2_vld_reg    <= 1'b0;
            tfound_reg    <= 1'b0;
            efound_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            tuple_cnt_reg <= tuple_cnt_next;
            entry_cnt_reg <= entry_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            t1_vld_reg    <= issue && cmd.tscan;
            e1_vld_reg    <= issue && cmd.escan;
            e2_vld_reg    <= e1_vld_reg;
            if (cmd.load)
            begin
                tfound_reg <= 1'b0;
                efound_reg <= 1'b0;
                hit_reg    <= 1'b0;
            end
            else
            begin
                if (t_match) tfound_reg <= 1'b1;
                if (e_ins_match) efound_reg <= 1'b1;
                if (e_cls_match) hit_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_cls_reg  <= req.req_type;
            pkt_reg     <= req_key(req);
            tuple_reg   <= make_tuple(req);
            ins_key_reg <= mask_key(req_key(req), make_tuple(req));
            pri_reg     <= pri_wide[PB-1:0];
        end
        t1_idx_reg  <= scan_idx_reg[TIDX_W-1:0];
        e2_key_reg  <= e1_key_reg;
        e2_tidx_reg <= e1_tidx_reg;
        e2_prio_reg <= e1_prio_reg;
        e2_idx_reg  <= e1_idx_reg;
        e1_idx_reg  <= scan_idx_reg[EIDX_W-1:0];
        if (t_match) tidx_found_reg <= t1_idx_reg;
        if (e_ins_match)
        begin
            eidx_reg  <= e2_idx_reg;
            eprio_reg <= e2_prio_reg;
        end
        if (e_cls_match) best_reg <= e2_prio_reg;
        rsp_reg <= rsp_next;
    end

    // Tuple store.
    always_ff @(posedge clk)
    begin
        if (tup_we) tup_mem[new_tidx] <= tuple_reg;
        tup_rd_reg <= tup_mem[tup_raddr];
    end

    // Entry store.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_key_mem[ent_waddr]  <= ins_key_reg;
            ent_tidx_mem[ent_waddr] <= new_tidx;
            ent_prio_mem[ent_waddr] <= ent_wprio;
        end
        e1_key_reg  <= ent_key_mem[scan_idx_reg[EIDX_W-1:0]];
        e1_tidx_reg <= ent_tidx_mem[scan_idx_reg[EIDX_W-1:0]];
        e1_prio_reg <= ent_prio_mem[scan_idx_reg[EIDX_W-1:0]];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_cnt_reg <= EC_W'(MAX_ENTRIES))
        else $error("entry count exceeds the store depth");

    a_tuple_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tuple_cnt_reg <= TC_W'(MAX_TUPLES))
        else $error("tuple count exceeds the table depth");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwritten before transfer");

    a_efound_tfound: assert property (@(posedge clk) disable iff (!rst_n)
        efound_reg |-> tfound_reg)
        else $error("entry match without a tuple match");

endmodule

`default_nettype wire

// ===== rtl/tuple_space_packet_classifier_core.sv =====
// Top level of the tuple space packet classifier.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | tspc_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready | tspc_pkg::rsp_t
//
// One request is processed at a time; the entry store scan sets the rate.
// A classify scans only the entry store. An insert scans the tuple table, and then
// the entry store only if the tuple was found.
// Reset clears the tuple and entry counts; the stores need no clearing pass.
// A stalled result stays in its output register while the next request is taken.
`default_nettype none

module tuple_space_packet_classifier_core #(
    parameter int MAX_TUPLES    = tspc_pkg::MAX_TUPLES_DEF,
    parameter int MAX_ENTRIES   = tspc_pkg::MAX_ENTRIES_DEF,
    parameter int PRIORITY_BITS = tspc_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tspc_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tspc_pkg::rsp_t      rsp
);
    import tspc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tspc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tspc_datapath #(
        .MAX_TUPLES    (MAX_TUPLES),
        .MAX_ENTRIES   (MAX_ENTRIES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== verif/tuple_space_packet_classifier_core_tb.sv =====
// Self-checking testbench for the tuple space packet classifier core.
`default_nettype none

module tuple_space_packet_classifier_core_tb;
    import tspc_pkg::*;

    localparam int TUPLE_CAP     = MAX_TUPLES_DEF;
    localparam int ENTRY_CAP     = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS  = 1440;
    localparam int DRAIN_CYCLES  = 400;
    localparam int STALL_LIMIT   = 20000;
    localparam int LONG_HOLD     = 1500;

    typedef struct {
        req_t        r;
        bit          typed;
        status_t     st;
        logic [15:0] pri;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Classifier state as the predictor sees it.
    tuple_len_t  tup_len [TUPLE_CAP];
    logic [15:0] tup_best [TUPLE_CAP];
    int          tup_n;
    key_t        ent_key [ENTRY_CAP];
    int          ent_tup [ENTRY_CAP];
    logic [15:0] ent_pri [ENTRY_CAP];
    int          ent_n;

    rsp_t        expected_rsp [$];
    int          errors;
    int          snd_idle;
    int          rcv_idle;
    bit          long_hold;
    int          quiet_cycles;

    // Random pools: a few tuples and a few header keys, so classifies hit.
    tuple_len_t  len_pool [6];
    key_t        key_pool [8];

    tuple_space_packet_classifier_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Keep the top len bits of a w-bit field.
    function automatic logic [31:0] keep_prefix(input logic [31:0] v, input int len,
                                                input int w);
        logic [63:0] m;
        if (len == 0)
            return '0;
        if (len >= w)
            return v;
        m = ~((64'd1 << (w - len)) - 64'd1);
        return v & m[31:0];
    endfunction

    function automatic key_t masked_key(input key_t k, input tuple_len_t t);
        key_t m;
        m.src   = keep_prefix(k.src, t.src, 32);
        m.dst   = keep_prefix(k.dst, t.dst, 32);
        m.sport = 16'(keep_prefix(32'(k.sport), t.sport, 16));
        m.dport = 16'(keep_prefix(32'(k.dport), t.dport, 16));
        m.proto = 8'(keep_prefix(32'(k.proto), t.proto, 8));
        return m;
    endfunction

    function automatic int clamp_len(input int len, input int w);
        return (len > w) ? w : len;
    endfunction

    // Apply one request to the predicted state and return its result.
    function automatic rsp_t classify_or_insert(input req_t r);
        rsp_t       o;
        key_t       k;
        key_t       mk;
        tuple_len_t t;
        int         ti;
        int         ei;
        bit         hit;
        k.src   = r.src_addr;
        k.dst   = r.dst_addr;
        k.sport = r.src_port;
        k.dport = r.dst_port;
        k.proto = r.protocol;
        o.status = ST_MISS;
        o.match_priority = '0;
        if (r.req_type == REQ_INSERT)
        begin
            t.src   = 6'(clamp_len(r.src_prefix_len, 32));
            t.dst   = 6'(clamp_len(r.dst_prefix_len, 32));
            t.sport = 5'(clamp_len(r.sport_prefix_len, 16));
            t.dport = 5'(clamp_len(r.dport_prefix_len, 16));
            t.proto = 4'(clamp_len(r.proto_prefix_len, 8));
            mk = masked_key(k, t);
            ti = -1;
            for (int i = 0; i < tup_n; i++)
                if (ti < 0 && tup_len[i] == t)
                    ti = i;
            ei = -1;
            if (ti >= 0)
                for (int i = 0; i < ent_n; i++)
                    if (ei < 0 && ent_tup[i] == ti && ent_key[i] == mk)
                        ei = i;
            if (ei >= 0)
            begin
                if (r.rule_priority < ent_pri[ei])
                    ent_pri[ei] = r.rule_priority;
                if (r.rule_priority < tup_best[ti])
                    tup_best[ti] = r.rule_priority;
                o.status = ST_MERGED;
                o.match_priority = ent_pri[ei];
            end
            else if (ent_n >= ENTRY_CAP || (ti < 0 && tup_n >= TUPLE_CAP))
                o.status = ST_FULL;
            else
            begin
                if (ti < 0)
                begin
                    ti = tup_n;
                    tup_len[ti] = t;
                    tup_best[ti] = r.rule_priority;
                    tup_n++;
                end
                else if (r.rule_priority < tup_best[ti])
                    tup_best[ti] = r.rule_priority;
                ent_key[ent_n] = mk;
                ent_tup[ent_n] = ti;
                ent_pri[ent_n] = r.rule_priority;
                ent_n++;
                o.status = ST_NEW;
                o.match_priority = r.rule_priority;
            end
        end
        else
        begin
            hit = 1'b0;
            for (int i = 0; i < tup_n; i++)
            begin
                mk = masked_key(k, tup_len[i]);
                for (int j = 0; j < ent_n; j++)
                    if (ent_tup[j] == i && ent_key[j] == mk &&
                        (!hit || ent_pri[j] < o.match_priority))
                    begin
                        hit = 1'b1;
                        o.match_priority = ent_pri[j];
                    end
            end
            o.status = hit ? ST_HIT : ST_MISS;
        end
        return o;
    endfunction

    function automatic req_t make_req(input logic kind, input key_t k,
                                      input tuple_len_t t, input logic [15:0] pri);
        req_t r;
        r.req_type         = kind;
        r.src_addr         = k.src;
        r.dst_addr         = k.dst;
        r.src_port         = k.sport;
        r.dst_port         = k.dport;
        r.protocol         = k.proto;
        r.src_prefix_len   = t.src;
        r.dst_prefix_len   = t.dst;
        r.sport_prefix_len = t.sport;
        r.dport_prefix_len = t.dport;
        r.proto_prefix_len = t.proto;
        r.rule_priority    = pri;
        return r;
    endfunction

    // Offer one request starting at a falling edge; the transfer is predicted at the
    // rising edge where it happens. A typed result replaces the prediction.
    task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t p;
        if ($urandom_range(0, 99) < snd_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < snd_idle)
                @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        p = classify_or_insert(r);
        expected_rsp.push_back(typed ? typed_rsp : p);
        @(negedge clk);
    endtask

    function automatic req_t random_req();
        key_t       k;
        tuple_len_t t;
        logic       kind;
        kind = ($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_CLASSIFY;
        if ($urandom_range(0, 99) < 80)
            k = key_pool[$urandom_range(0, 7)];
        else
            k = key_t'(104'({$urandom, $urandom, $urandom, $urandom}));
        // Occasionally disturb one bit so that near misses occur.
        if ($urandom_range(0, 9) == 0)
            k[$urandom_range(0, $bits(key_t) - 1)] ^= 1'b1;
        if (kind == REQ_CLASSIFY || $urandom_range(0, 99) < 12)
            t = tuple_len_t'(26'($urandom));
        else
            t = len_pool[$urandom_range(0, 5)];
        return make_req(kind, k, t, 16'($urandom));
    endfunction

    // Response side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status=%0d priority=%0d",
                         $time, rsp.status, rsp.match_priority);
            end
            else
            begin
                rsp_t e;
                e = expected_rsp.pop_front();
                if (rsp.status !== e.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, rsp.status);
                end
                if (rsp.match_priority !== e.match_priority)
                begin
                    errors++;
                    $display("%0t: match_priority expected %0d actual %0d",
                             $time, e.match_priority, rsp.match_priority);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        dir_row_t   dir [$];
        dir_row_t   row;
        key_t       zeros;
        key_t       ones;
        tuple_len_t wild;
        tuple_len_t over;
        tuple_len_t exact;
        tuple_len_t mid;
        rsp_t       typed_rsp;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        errors       = 0;
        quiet_cycles = 0;
        long_hold    = 1'b0;
        snd_idle     = 0;
        rcv_idle     = 0;
        tup_n        = 0;
        ent_n        = 0;
        foreach (len_pool[i])
            len_pool[i] = '{6'($urandom_range(0, 32)), 6'($urandom_range(0, 32)),
                            5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)),
                            4'($urandom_range(0, 8))};
        foreach (key_pool[i])
            key_pool[i] = key_t'(104'({$urandom, $urandom, $urandom, $urandom}));

        zeros = '0;
        ones  = '1;
        wild  = '0;
        over  = '1;
        exact = '{6'd32, 6'd32, 5'd16, 5'd16, 4'd8};
        mid   = '{6'd8, 6'd16, 5'd4, 5'd4, 4'd4};

        // Directed rows: empty table, wildcard rule, merges, saturation, extremes.
        dir.push_back('{make_req(REQ_CLASSIFY, ones, wild, 16'd0), 1, ST_MISS, 16'd0});
        dir.push_back('{make_req(REQ_INSERT, ones, wild, 16'd100), 1, ST_NEW, 16'd100});
        dir.push_back('{make_req(REQ_INSERT, zeros, wild, 16'd50), 1, ST_MERGED, 16'd50});
        dir.push_back('{make_req(REQ_INSERT, zeros, wild, 16'd200), 1, ST_MERGED, 16'd50});
        dir.push_back('{make_req(REQ_CLASSIFY, key_pool[0], wild, 16'd0), 1, ST_HIT,
                        16'd50});
        dir.push_back('{make_req(REQ_INSERT, ones, over, 16'hFFFF), 1, ST_NEW, 16'hFFFF});
        dir.push_back('{make_req(REQ_INSERT, ones, exact, 16'd7), 1, ST_MERGED, 16'd7});
        dir.push_back('{make_req(REQ_CLASSIFY, ones, wild, 16'd0), 1, ST_HIT, 16'd7});
        dir.push_back('{make_req(REQ_INSERT, zeros, mid, 16'd0), 1, ST_NEW, 16'd0});
        dir.push_back('{make_req(REQ_CLASSIFY, zeros, wild, 16'd0), 1, ST_HIT, 16'd0});
        dir.push_back('{make_req(REQ_CLASSIFY, zeros, over, 16'hFFFF), 1, ST_HIT, 16'd0});
        dir.push_back('{make_req(REQ_INSERT, key_pool[1], exact, 16'h1234), 0, ST_HIT, 0});
        dir.push_back('{make_req(REQ_CLASSIFY, key_pool[1], wild, 16'd0), 0, ST_HIT, 0});
        dir.push_back('{make_req(REQ_INSERT, key_pool[2], len_pool[0], 16'h8000), 0,
                        ST_HIT, 0});
        dir.push_back('{make_req(REQ_CLASSIFY, key_pool[2], wild, 16'd0), 0, ST_HIT, 0});
        dir.push_back('{make_req(REQ_INSERT, key_pool[3], '{6'd40, 6'd1, 5'd20, 5'd1,
                        4'd12}, 16'h00FF), 0, ST_HIT, 0});
        dir.push_back('{make_req(REQ_CLASSIFY, key_pool[3], wild, 16'd0), 0, ST_HIT, 0});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir[i])
        begin
            row = dir[i];
            typed_rsp.status = row.st;
            typed_rsp.match_priority = row.pri;
            send_req(row.r, row.typed, typed_rsp);
        end

        // Three idling profiles; the sender waits for all results between them.
        for (int ph = 0; ph < 3; ph++)
        begin
            req_valid <= 1'b0;
            while (expected_rsp.size() != 0)
                @(negedge clk);
            snd_idle = (ph == 0) ? 27 : (ph == 1) ? 62 : 0;
            rcv_idle = (ph == 0) ? 62 : (ph == 1) ? 27 : 0;
            if (ph == 2)
                long_hold = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_req(random_req(), 0, typed_rsp);
        end
        req_valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
